>>> hw/rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// Shared segment table package
// Sizes, codes and records shared by the segment table modules.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int TABLE_ENTRIES     = 64;
  localparam int PROCS_PER_SEGMENT = 64;

  localparam int ID_W    = 31;
  localparam int PID_W   = 16;
  localparam int FRAME_W = 20;
  localparam int SLOT_W  = $clog2(TABLE_ENTRIES);
  localparam int PIDX_W  = $clog2(PROCS_PER_SEGMENT);
  localparam int CNT_W   = $clog2(PROCS_PER_SEGMENT + 1);
  localparam int USED_W  = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    OP_ATTACH = 3'd0,
    OP_DETACH = 3'd1,
    OP_SET    = 3'd2,
    OP_STAT   = 3'd3,
    OP_REMOVE = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NO_FRAME     = 3'd1,
    ST_DUPLICATE    = 3'd2,
    ST_MARKED       = 3'd3,
    ST_NOT_FOUND    = 3'd4,
    ST_NOT_ATTACHED = 3'd5,
    ST_TABLE_FULL   = 3'd6,
    ST_LIST_FULL    = 3'd7
  } status_t;

  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_RW     = 2'd1;
  localparam logic [1:0] MODE_MARKED = 2'd2;

  typedef struct packed {
    logic [2:0]         operation;
    logic [ID_W-1:0]    segment_id;
    logic [PID_W-1:0]   process_id;
    logic               frame_offered;
    logic [FRAME_W-1:0] new_frame;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [FRAME_W-1:0] frame_out;
    logic               writable;
    logic [1:0]         mode_out;
    logic               created;
    logic               destroyed;
  } res_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [1:0]         mode;
    logic [FRAME_W-1:0] frame;
    logic [CNT_W-1:0]   count;
  } rec_t;

endpackage

>>> hw/rtl/sst_core.sv
// ----------------------------------------------------------------------------
// Shared segment table sequencer
// Holds the segment records and attach lists and walks them one entry per
// step, with one compare for record ids and one for list members.
// ----------------------------------------------------------------------------
module sst_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  sst_pkg::req_t req,
  output logic          idle,
  output logic          done,
  output sst_pkg::res_t res
);

  typedef enum logic [3:0] {
    S_IDLE, S_SREAD, S_SCMP, S_DECIDE, S_PREAD, S_PCMP, S_PEND, S_LREAD, S_LWAIT
  } state_t;

  localparam int PADDR_W = sst_pkg::SLOT_W + sst_pkg::PIDX_W;

  state_t                       state;
  sst_pkg::req_t                cur;
  logic [sst_pkg::SLOT_W-1:0]   idx;
  logic                         hit;
  logic [sst_pkg::SLOT_W-1:0]   hit_slot;
  logic [sst_pkg::SLOT_W-1:0]   free_slot;
  sst_pkg::rec_t                rec;
  logic [sst_pkg::CNT_W-1:0]    pidx;
  logic                         pfound;
  logic [sst_pkg::PIDX_W-1:0]   ppos;
  logic [sst_pkg::USED_W-1:0]   used;
  logic [sst_pkg::TABLE_ENTRIES-1:0] valid;

  sst_pkg::rec_t                rec_mem [sst_pkg::TABLE_ENTRIES];
  sst_pkg::rec_t                rec_rdata;
  logic [sst_pkg::SLOT_W-1:0]   rec_raddr;
  logic                         rec_we;
  logic [sst_pkg::SLOT_W-1:0]   rec_waddr;
  sst_pkg::rec_t                rec_wdata;

  logic [sst_pkg::PID_W-1:0]    pid_mem [2**PADDR_W];
  logic [sst_pkg::PID_W-1:0]    pid_rdata;
  logic [PADDR_W-1:0]           pid_raddr;
  logic                         pid_we;
  logic [PADDR_W-1:0]           pid_waddr;
  logic [sst_pkg::PID_W-1:0]    pid_wdata;

  logic                         id_match;
  logic                         pid_match;
  logic [sst_pkg::CNT_W-1:0]    count_dec;
  logic [sst_pkg::CNT_W-1:0]    count_inc;
  logic                         full;

  assign id_match  = valid[idx] && (rec_rdata.id == cur.segment_id);
  assign pid_match = (pid_rdata == cur.process_id);
  assign count_dec = rec.count - 1'b1;
  assign count_inc = rec.count + 1'b1;
  assign full      = (used == sst_pkg::USED_W'(sst_pkg::TABLE_ENTRIES));
  assign idle      = (state == S_IDLE);

  always_comb begin
    rec_raddr = idx;
    pid_raddr = {hit_slot, pidx[sst_pkg::PIDX_W-1:0]};
    if (state == S_LREAD) begin
      pid_raddr = {hit_slot, count_dec[sst_pkg::PIDX_W-1:0]};
    end
    rec_we    = 1'b0;
    rec_waddr = hit_slot;
    rec_wdata = rec;
    pid_we    = 1'b0;
    pid_waddr = {hit_slot, rec.count[sst_pkg::PIDX_W-1:0]};
    pid_wdata = cur.process_id;
    case (state)
      S_DECIDE: begin
        if (!hit && cur.operation == sst_pkg::OP_ATTACH && cur.frame_offered && !full) begin
          rec_we          = 1'b1;
          rec_waddr       = free_slot;
          rec_wdata.id    = cur.segment_id;
          rec_wdata.mode  = sst_pkg::MODE_RW;
          rec_wdata.frame = cur.new_frame;
          rec_wdata.count = sst_pkg::CNT_W'(1);
          pid_we          = 1'b1;
          pid_waddr       = {free_slot, sst_pkg::PIDX_W'(0)};
        end else if (hit && cur.operation == sst_pkg::OP_REMOVE && rec.count != '0) begin
          rec_we         = 1'b1;
          rec_wdata.mode = sst_pkg::MODE_MARKED;
        end
      end
      S_PEND: begin
        if (cur.operation == sst_pkg::OP_ATTACH) begin
          if (!pfound && rec.mode != sst_pkg::MODE_MARKED &&
              rec.count < sst_pkg::CNT_W'(sst_pkg::PROCS_PER_SEGMENT)) begin
            pid_we          = 1'b1;
            rec_we          = 1'b1;
            rec_wdata.count = count_inc;
          end
        end else if (pfound && rec.count == sst_pkg::CNT_W'(1) &&
                     rec.mode != sst_pkg::MODE_MARKED) begin
          rec_we          = 1'b1;
          rec_wdata.count = count_dec;
        end
      end
      S_LWAIT: begin
        pid_we          = 1'b1;
        pid_waddr       = {hit_slot, ppos};
        pid_wdata       = pid_rdata;
        rec_we          = 1'b1;
        rec_wdata.count = count_dec;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    rec_rdata <= rec_mem[rec_raddr];
  end

  always_ff @(posedge clk) begin
    if (pid_we) begin
      pid_mem[pid_waddr] <= pid_wdata;
    end
    pid_rdata <= pid_mem[pid_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      used  <= '0;
      valid <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cur    <= req;
            idx    <= '0;
            hit    <= 1'b0;
            res    <= '{status: sst_pkg::ST_OK, default: '0};
            if (req.operation inside {sst_pkg::OP_ATTACH, sst_pkg::OP_DETACH,
                                      sst_pkg::OP_STAT, sst_pkg::OP_REMOVE}) begin
              state <= S_SREAD;
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_SREAD: begin
          state <= S_SCMP;
        end
        S_SCMP: begin
          if (id_match) begin
            hit      <= 1'b1;
            hit_slot <= idx;
            rec      <= rec_rdata;
          end
          if (!valid[idx] && (idx == '0 || valid[free_slot] || free_slot >= idx)) begin
            free_slot <= idx;
          end
          if (id_match || idx == sst_pkg::SLOT_W'(sst_pkg::TABLE_ENTRIES - 1)) begin
            state <= S_DECIDE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SREAD;
          end
        end
        S_DECIDE: begin
          pidx   <= '0;
          pfound <= 1'b0;
          if (!hit) begin
            done  <= 1'b1;
            state <= S_IDLE;
            if (cur.operation == sst_pkg::OP_ATTACH) begin
              if (!cur.frame_offered) begin
                res.status <= sst_pkg::ST_NO_FRAME;
              end else if (full) begin
                res.status <= sst_pkg::ST_TABLE_FULL;
              end else begin
                valid[free_slot] <= 1'b1;
                used             <= used + 1'b1;
                res.frame_out    <= cur.new_frame;
                res.writable     <= 1'b1;
                res.created      <= 1'b1;
              end
            end else begin
              res.status <= sst_pkg::ST_NOT_FOUND;
            end
          end else begin
            case (cur.operation)
              sst_pkg::OP_STAT: begin
                res.mode_out <= rec.mode;
                done         <= 1'b1;
                state        <= S_IDLE;
              end
              sst_pkg::OP_REMOVE: begin
                if (rec.count == '0) begin
                  valid[hit_slot] <= 1'b0;
                  used            <= used - 1'b1;
                  res.destroyed   <= 1'b1;
                end
                done  <= 1'b1;
                state <= S_IDLE;
              end
              default: begin
                state <= (rec.count == '0) ? S_PEND : S_PREAD;
              end
            endcase
          end
        end
        S_PREAD: begin
          state <= S_PCMP;
        end
        S_PCMP: begin
          if (pid_match) begin
            pfound <= 1'b1;
            ppos   <= pidx[sst_pkg::PIDX_W-1:0];
          end
          if (pid_match || sst_pkg::CNT_W'(pidx + 1'b1) == rec.count) begin
            state <= S_PEND;
          end else begin
            pidx  <= pidx + 1'b1;
            state <= S_PREAD;
          end
        end
        S_PEND: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (cur.operation == sst_pkg::OP_ATTACH) begin
            if (pfound) begin
              res.status <= sst_pkg::ST_DUPLICATE;
            end else if (rec.mode == sst_pkg::MODE_MARKED) begin
              res.status <= sst_pkg::ST_MARKED;
            end else if (rec.count >= sst_pkg::CNT_W'(sst_pkg::PROCS_PER_SEGMENT)) begin
              res.status <= sst_pkg::ST_LIST_FULL;
            end else begin
              res.frame_out <= rec.frame;
              res.writable  <= (rec.mode == sst_pkg::MODE_RW);
            end
          end else if (!pfound) begin
            res.status <= sst_pkg::ST_NOT_ATTACHED;
          end else if (rec.count == sst_pkg::CNT_W'(1)) begin
            if (rec.mode == sst_pkg::MODE_MARKED) begin
              valid[hit_slot] <= 1'b0;
              used            <= used - 1'b1;
              res.destroyed   <= 1'b1;
            end
          end else begin
            done  <= 1'b0;
            state <= S_LREAD;
          end
        end
        S_LREAD: begin
          state <= S_LWAIT;
        end
        S_LWAIT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_used_matches_valid: assert property (@(posedge clk) disable iff (rst)
    32'(used) == $countones(valid))
    else $error("entry count disagrees with live slots");

  a_done_returns_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result given while the sequencer is still busy");

  a_create_grows_table: assert property (@(posedge clk) disable iff (rst)
    done && res.created |-> used == $past(used) + 1'b1)
    else $error("segment created without a new table entry");

  a_destroy_shrinks_table: assert property (@(posedge clk) disable iff (rst)
    done && res.destroyed |-> used == $past(used) - 1'b1)
    else $error("segment destroyed without freeing a table entry");

endmodule

>>> hw/rtl/shared_segment_table.sv
// ----------------------------------------------------------------------------
// Shared segment table
// Bounded table of shared segments with per-segment attach lists.
// ----------------------------------------------------------------------------
// One request is handled at a time. The segment search reads one record
// at a time from the record memory, which is all that stat, remove and a
// create need; attach and detach on an existing segment then search the
// attach list one member at a time, and a detach that leaves other members
// behind moves the last member into the freed place. Set and unused codes
// finish without a search.
// The request side is stalled until the result transfer has completed.
module shared_segment_table (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [2:0]                   operation,
  input  logic [sst_pkg::ID_W-1:0]     segment_id,
  input  logic [sst_pkg::PID_W-1:0]    process_id,
  input  logic                         frame_offered,
  input  logic [sst_pkg::FRAME_W-1:0]  new_frame,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [2:0]                   status,
  output logic [sst_pkg::FRAME_W-1:0]  frame_out,
  output logic                         writable,
  output logic [1:0]                   mode_out,
  output logic                         created,
  output logic                         destroyed
);

  sst_pkg::req_t req;
  sst_pkg::res_t res;
  sst_pkg::res_t held;
  logic          core_idle;
  logic          core_done;
  logic          start;

  assign req       = '{operation, segment_id, process_id, frame_offered, new_frame};
  assign req_stall = !core_idle || core_done || rsp_valid;
  assign start     = req_valid && !req_stall;

  sst_core u_core (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .idle (core_idle),
    .done (core_done),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (core_done) begin
      rsp_valid <= 1'b1;
      held      <= res;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  assign status    = held.status;
  assign frame_out = held.frame_out;
  assign writable  = held.writable;
  assign mode_out  = held.mode_out;
  assign created   = held.created;
  assign destroyed = held.destroyed;

endmodule
